[rtl/kpd_pkg.sv]
// Shared types and constants for the keypad matrix scanner with debounce.
// Holds the transfer payload structs, result kinds and register indexes.
// No dependencies.
package kpd_pkg;

   localparam int ROWS_DEFAULT    = 4;
   localparam int COLUMNS_DEFAULT = 3;
   localparam int KEYS_DEFAULT    = 12;

   localparam int COLUMN_SHIFT = 4;
   localparam int PORT_W       = 8;
   localparam int TIME_W       = 32;
   localparam int KIND_W       = 2;
   localparam int KEY_FIELD_W  = 4;
   localparam int DRIVE_W      = 8;

   localparam int DEBOUNCE_W   = 16;
   localparam int MAX_KEYS_W   = 4;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 16;

   localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd50;
   localparam logic [MAX_KEYS_W-1:0] MAX_KEYS_RESET = 4'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_DEBOUNCE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_KEYS = 2'd1;

   localparam logic [KIND_W-1:0] KIND_ROW     = 2'd0;
   localparam logic [KIND_W-1:0] KIND_PRESS   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd2;

   typedef struct packed {
      logic [PORT_W-1:0] port_byte;
      logic [TIME_W-1:0] time_ms;
   } req_type;

   typedef struct packed {
      logic [KIND_W-1:0]      kind;
      logic [KEY_FIELD_W-1:0] key;
      logic [DRIVE_W-1:0]     row_drive;
      logic                   last;
   } rsp_type;

   typedef struct packed {
      logic step;
      logic differs;
   } timer_ctl_type;

endpackage

[rtl/kpd_timer.sv]
// Per-key change start times and the shared elapsed-time compare.
// One key is visited per step; depends on kpd_pkg.
module kpd_timer #(
   parameter int KEYS = kpd_pkg::KEYS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [(KEYS > 1 ? $clog2(KEYS) : 1)-1:0] key_index,
   input  logic [kpd_pkg::TIME_W-1:0]          now,
   input  logic [kpd_pkg::DEBOUNCE_W-1:0]      debounce_ms,
   input  kpd_pkg::timer_ctl_type              ctl,
   output logic                                expired
);

   localparam int TW = kpd_pkg::TIME_W;

   logic [TW-1:0] start_ff [KEYS];
   logic [TW-1:0] entry;
   logic [TW-1:0] elapsed;

   assign entry   = start_ff[key_index];
   assign elapsed = now - entry;
   assign expired = ctl.differs && (entry != '0) && (elapsed >= TW'(debounce_ms));

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < KEYS; k++) begin
            start_ff[k] <= '0;
         end
      end else if (ctl.step) begin
         if (!ctl.differs) begin
            start_ff[key_index] <= '0;
         end else if (entry == '0) begin
            start_ff[key_index] <= now;
         end
      end
   end

endmodule

[rtl/keypad_matrix_scan_debounce.sv]
// Keypad matrix scanner with debounce: one row read per transfer in, events out.
// A mid-frame row goes straight on to the row select; the row that closes a frame
// first counts the pressed keys, then judges the count for ghosting, then visits each
// key through the shared start-time compare, then drives the row select; a result
// stall holds it. A new transfer is taken only after the row select has gone out.
// Synchronous reset clears scan state, start times, and sets registers to 50 and 2.
module keypad_matrix_scan_debounce #(
   parameter int ROWS    = kpd_pkg::ROWS_DEFAULT,
   parameter int COLUMNS = kpd_pkg::COLUMNS_DEFAULT,
   parameter int KEYS    = kpd_pkg::KEYS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  kpd_pkg::req_type                   req_payload,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output kpd_pkg::rsp_type                   rsp_payload,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [kpd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [kpd_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int ROW_W  = ROWS > 1 ? $clog2(ROWS) : 1;
   localparam int KEY_W  = KEYS > 1 ? $clog2(KEYS) : 1;
   localparam int CNT_W  = $clog2(KEYS + 1);
   localparam int CMP_W  = CNT_W > kpd_pkg::MAX_KEYS_W ? CNT_W : kpd_pkg::MAX_KEYS_W;
   localparam int KF_W   = kpd_pkg::KEY_FIELD_W;
   localparam int DRV_W  = kpd_pkg::DRIVE_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COUNT,
      ST_JUDGE,
      ST_WALK,
      ST_DRIVE
   } state_type;

   state_type                          state_ff, state_in;
   logic [ROW_W-1:0]                   row_ff, row_in;
   logic [KEYS-1:0]                    frame_ff, frame_in;
   logic [KEYS-1:0]                    stable_ff, stable_in;
   logic [kpd_pkg::TIME_W-1:0]         now_ff, now_in;
   logic [KEY_W-1:0]                   key_ff, key_in;
   logic [CNT_W-1:0]                   count_ff, count_in;
   logic [kpd_pkg::DEBOUNCE_W-1:0]     debounce_ff, debounce_in;
   logic [kpd_pkg::MAX_KEYS_W-1:0]     max_ff, max_in;
   kpd_pkg::rsp_type                   rsp_ff, rsp_in;
   logic                               rsp_valid_ff, rsp_valid_in;

   logic [KEYS-1:0]                    frame_hit;
   logic [ROW_W-1:0]                   row_next;
   logic                               row_wrap;
   logic                               key_last;
   logic                               out_free;
   logic                               timer_expired;
   kpd_pkg::timer_ctl_type             timer_ctl;

   for (genvar k = 0; k < KEYS; k++) begin : g_hit
      localparam int ROW_K = k / COLUMNS;
      localparam int COL_K = k % COLUMNS;
      if (ROW_K < ROWS) begin : g_on
         assign frame_hit[k] = (row_ff == ROW_W'(ROW_K))
                               && !req_payload.port_byte[kpd_pkg::COLUMN_SHIFT + COL_K];
      end else begin : g_off
         assign frame_hit[k] = 1'b0;
      end
   end

   assign row_wrap  = row_ff == ROW_W'(ROWS - 1);
   assign row_next  = row_wrap ? '0 : row_ff + ROW_W'(1);
   assign key_last  = key_ff == KEY_W'(KEYS - 1);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign req_ready   = state_ff == ST_IDLE;
   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   kpd_timer #(
      .KEYS (KEYS)
   ) u_timer (
      .clock       (clock),
      .reset       (reset),
      .key_index   (key_ff),
      .now         (now_ff),
      .debounce_ms (debounce_ff),
      .ctl         (timer_ctl),
      .expired     (timer_expired)
   );

   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      frame_in     = frame_ff;
      stable_in    = stable_ff;
      now_in       = now_ff;
      key_in       = key_ff;
      count_in     = count_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      debounce_in  = debounce_ff;
      max_in       = max_ff;
      timer_ctl.step    = 1'b0;
      timer_ctl.differs = frame_ff[key_ff] ^ stable_ff[key_ff];

      if (csr_valid) begin
         case (csr_index)
            kpd_pkg::CSR_DEBOUNCE: debounce_in = csr_data[kpd_pkg::DEBOUNCE_W-1:0];
            kpd_pkg::CSR_MAX_KEYS: max_in = csr_data[kpd_pkg::MAX_KEYS_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               frame_in = frame_ff | frame_hit;
               row_in   = row_next;
               now_in   = req_payload.time_ms;
               key_in   = '0;
               count_in = '0;
               state_in = row_wrap ? ST_COUNT : ST_DRIVE;
            end
         end
         ST_COUNT: begin
            count_in = count_ff + CNT_W'(frame_ff[key_ff]);
            if (key_last) begin
               key_in   = '0;
               state_in = ST_JUDGE;
            end else begin
               key_in = key_ff + KEY_W'(1);
            end
         end
         ST_JUDGE: begin
            // drop the whole frame as ghosting
            if (CMP_W'(count_ff) > CMP_W'(max_ff)) begin
               frame_in = '0;
            end
            state_in = ST_WALK;
         end
         ST_WALK: begin
            if (!timer_expired || out_free) begin
               timer_ctl.step = 1'b1;
               if (timer_expired) begin
                  stable_in[key_ff] = !stable_ff[key_ff];
                  rsp_in.kind      = stable_ff[key_ff] ? kpd_pkg::KIND_RELEASE
                                                       : kpd_pkg::KIND_PRESS;
                  rsp_in.key       = KF_W'(key_ff);
                  rsp_in.row_drive = '0;
                  rsp_in.last      = 1'b0;
                  rsp_valid_in     = 1'b1;
               end
               if (key_last) begin
                  frame_in = '0;
                  state_in = ST_DRIVE;
               end else begin
                  key_in = key_ff + KEY_W'(1);
               end
            end
         end
         ST_DRIVE: begin
            if (out_free) begin
               rsp_in.kind      = kpd_pkg::KIND_ROW;
               rsp_in.key       = '0;
               rsp_in.row_drive = ~(DRV_W'(1) << row_ff);
               rsp_in.last      = 1'b1;
               rsp_valid_in     = 1'b1;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         row_ff       <= '0;
         frame_ff     <= '0;
         stable_ff    <= '0;
         key_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         debounce_ff  <= kpd_pkg::DEBOUNCE_RESET;
         max_ff       <= kpd_pkg::MAX_KEYS_RESET;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         frame_ff     <= frame_in;
         stable_ff    <= stable_in;
         key_ff       <= key_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         debounce_ff  <= debounce_in;
         max_ff       <= max_in;
      end
      now_ff <= now_in;
      rsp_ff <= rsp_in;
   end

endmodule
